// ===== hdl/ple_pkg.sv =====
// shared types and constants for the positional list engine
// no dependencies
package ple_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int POS_W      = 8;
    localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 5;

    localparam int IN_BITS    = OP_W + POS_W + DATA_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + DATA_W + LEN_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic [IDX_W-1:0]      sel;
        logic [ITEM_WIDTH-1:0] item;
    } cell_cmd_t;

endpackage

// ===== hdl/positional_list_engine_core.sv =====
// top level of the positional list engine: request decode, cell row, result register
// depends on ple_pkg and ple_cell
//
// Takes one request word per clock while the result register is empty or
// being drained, and returns one result word in the cycle after it is
// accepted. The cells of the row load, shift or hold together in the same
// cycle, and a read goes through an or-chain along the row, so insert, get,
// delete and clear all act on the list in the cycle they are accepted.
module positional_list_engine_core
    import ple_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op, position, item_value, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, item_out, length_out, zero pad
);

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    logic [OP_W-1:0]     op;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   item_value;
    logic                accept;
    logic [CMP_W-1:0]    pos_x;
    logic [CMP_W-1:0]    cnt_x;
    logic                full;
    logic                in_range;
    cell_cmd_t           cmd;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   item_out;
    logic [ITEM_WIDTH-1:0] chain_item;

    logic [ITEM_WIDTH-1:0] cell_value [DEPTH];
    logic [ITEM_WIDTH-1:0] cell_read  [DEPTH+1];

    assign op         = s_tdata[OP_W-1:0];
    assign position   = s_tdata[OP_W+POS_W-1:OP_W];
    assign item_value = s_tdata[IN_BITS-1:OP_W+POS_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_x    = CMP_W'(position);
    assign cnt_x    = CMP_W'(count_reg);
    assign full     = (count_reg == COUNT_W'(DEPTH));
    assign in_range = (pos_x < cnt_x);

    assign chain_item = cell_read[DEPTH];

    always_comb
    begin
        cmd        = '0;
        cmd.item   = ITEM_WIDTH'(item_value);
        cmd.sel    = IDX_W'(position);
        status     = ST_OK;
        item_out   = '0;
        count_next = count_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.ins    = accept;
                    if (pos_x > cnt_x)
                        cmd.sel = IDX_W'(count_reg);
                    count_next = COUNT_W'(count_reg + 1'b1);
                end
            end
            OP_GET:
            begin
                if (in_range)
                    item_out = DATA_W'(chain_item);
                else
                    status = ST_NOT_FOUND;
            end
            OP_DELETE:
            begin
                if (in_range)
                begin
                    cmd.del    = accept;
                    item_out   = DATA_W'(chain_item);
                    count_next = COUNT_W'(count_reg - 1'b1);
                end
                else
                    status = ST_NOT_FOUND;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign cell_read[0] = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [ITEM_WIDTH-1:0] left_v;
            logic [ITEM_WIDTH-1:0] right_v;
            if (g == 0)
            begin : g_first
                assign left_v = '0;
            end
            else
            begin : g_mid_l
                assign left_v = cell_value[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_v = '0;
            end
            else
            begin : g_mid_r
                assign right_v = cell_value[g+1];
            end
            ple_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .my_index    (IDX_W'(g)),
                .left_value  (left_v),
                .right_value (right_v),
                .read_in     (cell_read[g]),
                .value       (cell_value[g]),
                .read_out    (cell_read[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {LEN_W'(count_next), item_out, status};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

// ===== hdl/ple_cell.sv =====
// one list slot: holds an entry, shifts with its neighbors, joins the read chain
// depends on ple_pkg
module ple_cell
    import ple_pkg::*;
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [IDX_W-1:0]      my_index,
    input  logic [ITEM_WIDTH-1:0] left_value,
    input  logic [ITEM_WIDTH-1:0] right_value,
    input  logic [ITEM_WIDTH-1:0] read_in,
    output logic [ITEM_WIDTH-1:0] value,
    output logic [ITEM_WIDTH-1:0] read_out
);

    logic [ITEM_WIDTH-1:0] value_reg;
    logic [ITEM_WIDTH-1:0] value_next;
    logic                  hit;
    logic                  above;

    assign hit   = (my_index == cmd.sel);
    assign above = (my_index > cmd.sel);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (hit)
                value_next = cmd.item;
            else if (above)
                value_next = left_value;
        end
        else if (cmd.del)
        begin
            if (hit || above)
                value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value    = value_reg;
    assign read_out = read_in | (hit ? value_reg : '0);

endmodule

// ===== hdl/ple_checker.sv =====
// port-level checks for the positional list engine, bound to the top level
// depends on ple_pkg and positional_list_engine_core
module ple_checker
    import ple_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [DATA_W-1:0]   itm;
    logic [LEN_W-1:0]    len;

    assign st  = m_tdata[STATUS_W-1:0];
    assign itm = m_tdata[STATUS_W+DATA_W-1:STATUS_W];
    assign len = m_tdata[OUT_BITS-1:STATUS_W+DATA_W];

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (len <= LEN_W'(DEPTH)))
        else $error("length above depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st == ST_OK || st == ST_NOT_FOUND || st == ST_FULL))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st != ST_OK) |-> (itm == '0))
        else $error("item not zero on failure");

    a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[OP_W-1:0] == OP_CLEAR)
        |=> (m_tvalid && len == '0 && st == ST_OK))
        else $error("clear did not empty list");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);
